// ===== hdl/b64sc_pkg.sv =====
// Shared types, constants and lookup functions for the base64 stream codec.
// No dependencies.
package b64sc_pkg;

    localparam int MAX_ITEMS = 4;
    localparam int ITEM_IDX_W = 2;
    localparam int JOB_CNT_W = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } b64sc_mode_t;

    typedef struct packed
    {
        logic [7:0] value;
        logic       is_status;
        logic       bad_input;
        logic       end_of_message;
    } b64sc_item_t;

    // One request's worth of results, oldest in items[0]
    typedef struct packed
    {
        logic [JOB_CNT_W-1:0]            count;
        b64sc_item_t [MAX_ITEMS-1:0]     items;
    } b64sc_job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
                c = 8'h41 + {2'b00, v};
            else if (v < 6'd52)
                c = 8'h61 + {2'b00, v - 6'd26};
            else if (v < 6'd62)
                c = 8'h30 + {2'b00, v - 6'd52};
            else if (v == 6'd62)
                c = 8'h2B;
            else
                c = 8'h2F;
            return c;
        end
    endfunction

    // {valid, 6-bit value}
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                r = {1'b1, 6'(c - 8'h41)};
            else if (c >= 8'h61 && c <= 8'h7A)
                r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            else if (c >= 8'h30 && c <= 8'h39)
                r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            else if (c == 8'h2B)
                r = {1'b1, 6'd62};
            else if (c == 8'h2F)
                r = {1'b1, 6'd63};
            else
                r = 7'd0;
            return r;
        end
    endfunction

endpackage

// ===== hdl/b64sc_front.sv =====
// Front end: accepts requests, keeps message state, builds result jobs.
// Depends on b64sc_pkg.
module b64sc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [7:0]           symbol,
    input  logic                 final_req,
    input  logic                 cfg_wr,
    input  logic                 cfg_mode,
    output logic                 enq,
    output b64sc_pkg::b64sc_job_t job
);
    import b64sc_pkg::*;

    b64sc_mode_t mode_reg, mode_next;
    logic [15:0] held_reg, held_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        take;
    logic [2:0]  n;
    logic [23:0] grp;
    logic [6:0]  cv;
    logic [11:0] acc_sh;
    logic [3:0]  bits;
    logic [3:0]  sh;
    logic        bad;
    b64sc_job_t  job_c;

    assign take = push && !full;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        job_c     = '0;
        n         = {1'b0, hcnt_reg} + 3'd1;
        grp       = '0;
        cv        = dec_char(symbol);
        acc_sh    = {acc_reg[5:0], cv[5:0]};
        bits      = {1'b0, pend_reg} + 4'd6;
        sh        = bits - 4'd8;
        bad       = 1'b0;

        if (cfg_wr)
        begin
            mode_next = b64sc_mode_t'(cfg_mode);
            held_next = '0;
            hcnt_next = '0;
            acc_next  = '0;
            pend_next = '0;
            pad_next  = 1'b0;
            err_next  = 1'b0;
        end
        else if (take)
        begin
            case (mode_reg)
                MODE_ENCODE:
                begin
                    if (n < 3'd3 && !final_req)
                    begin
                        held_next = {held_reg[7:0], symbol};
                        hcnt_next = n[1:0];
                    end
                    else
                    begin
                        case (n)
                            3'd1:    grp = {symbol, 16'h0000};
                            3'd2:    grp = {held_reg[7:0], symbol, 8'h00};
                            default: grp = {held_reg, symbol};
                        endcase
                        job_c.count = 3'd4;
                        job_c.items[0].value = enc_char(grp[23:18]);
                        job_c.items[1].value = enc_char(grp[17:12]);
                        job_c.items[2].value = (n >= 3'd2) ? enc_char(grp[11:6]) : PAD_CHAR;
                        job_c.items[3].value = (n >= 3'd3) ? enc_char(grp[5:0]) : PAD_CHAR;
                        job_c.items[3].end_of_message = final_req;
                        held_next = '0;
                        hcnt_next = '0;
                    end
                end
                MODE_DECODE:
                begin
                    if (!err_reg)
                    begin
                        if (symbol == PAD_CHAR)
                            pad_next = 1'b1;
                        else if (pad_reg || !cv[6])
                            err_next = 1'b1;
                        else if (bits >= 4'd8)
                        begin
                            job_c.count = 3'd1;
                            job_c.items[0].value = 8'(acc_sh >> sh);
                            acc_next  = acc_sh & ((12'd1 << sh) - 12'd1);
                            pend_next = sh[2:0];
                        end
                        else
                        begin
                            acc_next  = acc_sh;
                            pend_next = bits[2:0];
                        end
                    end
                    if (final_req)
                    begin
                        bad = err_next || (pend_next == 3'd6)
                            || (pend_next != 3'd0 && acc_next != 12'd0);
                        // status goes after any byte from this character
                        job_c.items[job_c.count[ITEM_IDX_W-1:0]].is_status      = 1'b1;
                        job_c.items[job_c.count[ITEM_IDX_W-1:0]].bad_input      = bad;
                        job_c.items[job_c.count[ITEM_IDX_W-1:0]].end_of_message = 1'b1;
                        job_c.count = job_c.count + 3'd1;
                    end
                end
                default:
                begin
                    job_c = '0;
                end
            endcase
            if (final_req)
            begin
                held_next = '0;
                hcnt_next = '0;
                acc_next  = '0;
                pend_next = '0;
                pad_next  = 1'b0;
                err_next  = 1'b0;
            end
        end
    end

    assign enq = take && (job_c.count != '0);
    assign job = job_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            held_reg <= '0;
            hcnt_reg <= '0;
            acc_reg  <= '0;
            pend_reg <= '0;
            pad_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            hcnt_reg <= hcnt_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

// ===== hdl/b64sc_queue.sv =====
// Short job queue between front and back ends, held in flip-flops.
// Depends on b64sc_pkg.
module b64sc_queue #(
    parameter int QDEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enq,
    input  b64sc_pkg::b64sc_job_t enq_job,
    input  logic                  deq,
    output logic                  full,
    output logic                  head_valid,
    output b64sc_pkg::b64sc_job_t head_job
);
    import b64sc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    b64sc_job_t      mem_reg [QDEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (enq)
            wr_next = (wr_reg == PW'(QDEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (deq)
            rd_next = (rd_reg == PW'(QDEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (enq && !deq)
            cnt_next = cnt_reg + CW'(1);
        else if (!enq && deq)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            mem_reg[wr_reg] <= enq_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/b64sc_back.sv =====
// Back end: walks the head job one result at a time into the output register.
// Depends on b64sc_pkg.
module b64sc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  b64sc_pkg::b64sc_job_t head_job,
    output logic                  deq,
    input  logic                  pop,
    output logic                  empty,
    output b64sc_pkg::b64sc_item_t item
);
    import b64sc_pkg::*;

    logic [ITEM_IDX_W-1:0] idx_reg, idx_next;
    logic                  ov_reg, ov_next;
    b64sc_item_t           item_reg;
    logic                  load;
    logic                  last;

    assign load = head_valid && (!ov_reg || pop);
    assign last = ({1'b0, idx_reg} == head_job.count - 3'd1);
    assign deq  = load && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (deq)
            idx_next = '0;
        else if (load)
            idx_next = idx_reg + ITEM_IDX_W'(1);
        ov_next = load || (ov_reg && !pop);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= head_job.items[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    assign empty = !ov_reg;
    assign item  = item_reg;

endmodule

// ===== hdl/base64_stream_codec.sv =====
// Base64 stream codec, encode or decode selected by the mode register.
// Path: a request's results are written into the job queue, then loaded one at a time into the output register.
// Throughput: one request per cycle while the job queue (QDEPTH jobs) has room; results
// leave at one per cycle while pop is held, so an encode group of four results takes four pops to leave.
// Reset: asynchronous, clears message state, empties queue and output; mode returns to encode.
module base64_stream_codec #(
    parameter int QDEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] symbol,
    input  logic       final_req,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] value,
    output logic       is_status,
    output logic       bad_input,
    output logic       end_of_message,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_mode
);
    import b64sc_pkg::*;

    logic        enq;
    logic        deq;
    logic        head_valid;
    b64sc_job_t  new_job;
    b64sc_job_t  head_job;
    b64sc_item_t out_item;

    assign cfg_ready = 1'b1;

    b64sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .symbol    (symbol),
        .final_req (final_req),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_mode  (cfg_mode),
        .enq       (enq),
        .job       (new_job)
    );

    b64sc_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .enq_job    (new_job),
        .deq        (deq),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64sc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .item       (out_item)
    );

    assign value          = out_item.value;
    assign is_status      = out_item.is_status;
    assign bad_input      = out_item.bad_input;
    assign end_of_message = out_item.end_of_message;

endmodule

// ===== test/base64_stream_codec_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_codec: encode and decode traffic with a scoreboard.
// Depends on hdl/b64sc_pkg.sv and hdl/base64_stream_codec.sv.
module base64_stream_codec_tb;
    import b64sc_pkg::*;

    localparam int TARGET_ITEMS = 230;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    // Tracks the codec's message state and the characters/bytes it should emit.
    class codec_scoreboard;
        string alphabet;
        b64sc_mode_t mode;
        logic [23:0] group;
        int unsigned group_len;
        logic [11:0] bit_acc;
        int unsigned bit_cnt;
        bit pad_seen;
        bit dec_error;
        b64sc_item_t expected_q[$];
        int unsigned errors;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            mode = MODE_ENCODE;
            errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            group = '0;
            group_len = 0;
            bit_acc = '0;
            bit_cnt = 0;
            pad_seen = 1'b0;
            dec_error = 1'b0;
        endfunction

        function void set_mode(b64sc_mode_t m);
            mode = m;
            clear_message();
        endfunction

        function logic [7:0] b64_char(logic [5:0] v);
            return alphabet[v];
        endfunction

        function int sextet_of(logic [7:0] c);
            for (int i = 0; i < 64; i++)
            begin
                if (alphabet[i] == c)
                    return i;
            end
            return -1;
        endfunction

        function void expect_item(logic [7:0] v, bit st, bit bad, bit eom);
            b64sc_item_t it;
            it.value = v;
            it.is_status = st;
            it.bad_input = bad;
            it.end_of_message = eom;
            expected_q.push_back(it);
        endfunction

        function void encode_byte(logic [7:0] sym, bit fin);
            int unsigned n;
            logic [23:0] v;
            group = {group[15:0], sym};
            n = group_len + 1;
            if (n < 3 && !fin)
            begin
                group_len = n;
                group[23:16] = 8'h00;
            end
            else
            begin
                v = group;
                if (n == 1)
                    v = v << 16;
                else if (n == 2)
                    v = v << 8;
                expect_item(b64_char(v[23:18]), 1'b0, 1'b0, 1'b0);
                expect_item(b64_char(v[17:12]), 1'b0, 1'b0, 1'b0);
                expect_item((n >= 2) ? b64_char(v[11:6]) : PAD_CHAR, 1'b0, 1'b0, 1'b0);
                expect_item((n >= 3) ? b64_char(v[5:0]) : PAD_CHAR, 1'b0, 1'b0, fin);
                clear_message();
            end
        endfunction

        function void decode_char(logic [7:0] sym, bit fin);
            int sx;
            int unsigned nb;
            logic [11:0] acc;
            bit bad;
            if (!dec_error)
            begin
                sx = sextet_of(sym);
                if (sym == PAD_CHAR)
                    pad_seen = 1'b1;
                else if (pad_seen || sx < 0)
                    dec_error = 1'b1;
                else
                begin
                    acc = (bit_acc << 6) | 12'(sx);
                    nb = bit_cnt + 6;
                    if (nb >= 8)
                    begin
                        nb = nb - 8;
                        expect_item(8'(acc >> nb), 1'b0, 1'b0, 1'b0);
                        acc = acc & ((12'd1 << nb) - 12'd1);
                    end
                    bit_acc = acc;
                    bit_cnt = nb;
                end
            end
            if (fin)
            begin
                // leftover single char or nonzero unused bits both fail the message
                bad = dec_error || bit_cnt == 6 || (bit_cnt > 0 && bit_acc != 0);
                expect_item(8'h00, 1'b1, bad, 1'b1);
                clear_message();
            end
        endfunction

        function void note_request(logic [7:0] sym, bit fin);
            if (mode == MODE_ENCODE)
                encode_byte(sym, fin);
            else
                decode_char(sym, fin);
        endfunction

        function void check_result(b64sc_item_t got);
            b64sc_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: value=%02h is_status=%0b bad_input=%0b eom=%0b",
                       got.value, got.is_status, got.bad_input, got.end_of_message);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.value !== want.value)
                begin
                    $error("value: expected %02h, got %02h", want.value, got.value);
                    errors++;
                end
                if (got.is_status !== want.is_status)
                begin
                    $error("is_status: expected %0b, got %0b", want.is_status, got.is_status);
                    errors++;
                end
                if (got.bad_input !== want.bad_input)
                begin
                    $error("bad_input: expected %0b, got %0b", want.bad_input, got.bad_input);
                    errors++;
                end
                if (got.end_of_message !== want.end_of_message)
                begin
                    $error("end_of_message: expected %0b, got %0b",
                           want.end_of_message, got.end_of_message);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] symbol;
    logic       final_req;
    logic       empty;
    logic       pop;
    logic [7:0] value;
    logic       is_status;
    logic       bad_input;
    logic       end_of_message;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_mode;

    codec_scoreboard sb;
    logic [7:0] msg_q[$];
    int unsigned items_sent;
    int unsigned burst_left;
    bit steady;
    bit hold_req;
    int unsigned hold_left;
    int unsigned rx_cycle;
    int unsigned rx_style;
    int unsigned idle_cycles;

    base64_stream_codec DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .symbol         (symbol),
        .final_req      (final_req),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .is_status      (is_status),
        .bad_input      (bad_input),
        .end_of_message (end_of_message),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_mode       (cfg_mode)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check every popped item, then pick next cycle's pop
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result('{value, is_status, bad_input, end_of_message});
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_style = $urandom_range(0, 3);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (rx_style)
                    0: pop <= 1'b1;
                    1: pop <= rx_cycle[0];
                    2: pop <= ($urandom_range(0, 9) >= 3);
                    default: pop <= (rx_cycle % 5 >= 3);
                endcase
            end
        end
    end

    // Watchdog: any accepted request, result or register write resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Sends msg_q, final_req on the last item unless the message is left open;
    // bursts with random gaps unless steady is set
    task automatic send_msg(input bit with_final = 1'b1);
        bit fin;
        for (int i = 0; i < msg_q.size(); i++)
        begin
            fin = with_final && (i == msg_q.size() - 1);
            push <= 1'b1;
            symbol <= msg_q[i];
            final_req <= fin;
            do
                @(posedge clk);
            while (full);
            sb.note_request(msg_q[i], fin);
            items_sent++;
            if (!steady)
            begin
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 6);
                end
            end
        end
    endtask

    task automatic send_text(input string s, input bit with_final = 1'b1);
        msg_q = {};
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
        send_msg(with_final);
    endtask

    // Stop offering and wait until every expected result is out, plus settle time
    task automatic drain();
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input b64sc_mode_t m);
        drain();
        cfg_mode <= m;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic build_byte_msg();
        msg_q = {};
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 7))
            msg_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed base64 text with random content; some noise and broken text
    task automatic build_text_msg();
        int unsigned kind;
        int unsigned quads;
        int unsigned tail;
        int unsigned pads;
        msg_q = {};
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
                msg_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            quads = $urandom_range(0, 3);
            tail = (quads == 0) ? $urandom_range(2, 3) : $urandom_range(0, 3);
            if (tail == 1)
                tail = 0;
            repeat (quads * 4)
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 63))));
            pads = 0;
            if (tail == 2)
            begin
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 63))));
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 3) << 4)));
                pads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 2;
            end
            else if (tail == 3)
            begin
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 63))));
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 63))));
                msg_q.push_back(sb.b64_char(6'($urandom_range(0, 15) << 2)));
                pads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
            end
            repeat (pads)
                msg_q.push_back(PAD_CHAR);
            case (kind)
                1: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
                2: msg_q.push_back(sb.b64_char(6'($urandom_range(0, 63))));
                3: msg_q.insert($urandom_range(0, msg_q.size() - 1), PAD_CHAR);
                4:
                begin
                    // unused low bits of the last data char likely nonzero
                    if (tail != 0)
                        msg_q[quads * 4 + tail - 1] = sb.b64_char(6'($urandom_range(0, 63)));
                end
                default: ;
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        symbol = 8'h00;
        final_req = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_mode = MODE_ENCODE;
        items_sent = 0;
        burst_left = 3;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        rx_cycle = 0;
        rx_style = 0;
        idle_cycles = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode in the reset mode: one and two byte tails, group completed by final
        msg_q = {8'h00};
        send_msg();
        msg_q = {8'hFF, 8'hFF};
        send_msg();
        msg_q = {8'h00, 8'hFF, 8'h80};
        send_msg();
        // same-mode write mid-message drops the held byte
        msg_q = {8'hAB};
        send_msg(1'b0);
        msg_q.delete();
        write_mode(MODE_ENCODE);
        msg_q = {8'hCD};
        send_msg();

        write_mode(MODE_DECODE);
        send_text("TWFu");      // final char emits a byte, then status
        send_text("QQ===");     // extra padding accepted
        send_text("TR=");       // nonzero unused bits
        msg_q = {8'hFF};        // invalid char
        send_msg();
        send_text("Q=A");       // data after padding
        send_text("Q");         // single leftover char
        send_text("TW", 1'b0);  // left open, dropped by the mode write
        write_mode(MODE_DECODE);
        send_text("TWFu");

        for (int phase = 0; items_sent < TARGET_ITEMS; phase++)
        begin
            int unsigned budget;
            budget = items_sent + 35;
            write_mode((phase % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
            if (phase == 0)
            begin
                // receiver holds off while the sender keeps pushing: fills the block
                steady = 1'b1;
                hold_req = 1'b1;
                msg_q = {};
                repeat (30)
                    msg_q.push_back(8'($urandom_range(0, 255)));
                send_msg();
                steady = 1'b0;
            end
            while (items_sent < budget)
            begin
                if (phase % 2 == 0)
                    build_byte_msg();
                else
                    build_text_msg();
                send_msg();
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
